// ----- rtl/core/stepper_motor_limit_switch_model_top_assert.svh -----
// Assertion macros for the stepper motor limit switch model.
`ifndef STEPPER_MOTOR_LIMIT_SWITCH_MODEL_TOP_ASSERT_SVH
`define STEPPER_MOTOR_LIMIT_SWITCH_MODEL_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define SMLS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("smls assertion failed");
// consequent must hold in the cycle after the antecedent
`define SMLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smls assertion failed");
`else
`define SMLS_ASSERT(lbl, clk, rst_n, prop)
`define SMLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/smls_pkg.sv -----
`default_nettype none
package smls_pkg;

  localparam int unsigned PosWidthDef  = 32;
  localparam int unsigned PhaseBitsDef = 10;

  localparam int unsigned OpW       = 3;
  localparam int unsigned FracW     = 17;
  localparam int unsigned MsW       = 9;
  localparam int unsigned MsCountW  = 10;
  localparam int unsigned VelW      = 6;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned InTdataW  = 56;
  localparam int unsigned OutTdataW = 120;
  localparam int unsigned DivSteps  = 8;
  localparam int unsigned DivCntW   = 3;
  localparam int unsigned MulCntW   = $clog2(FracW);

  localparam logic [FracW-1:0]    FracOne     = 17'h10000;
  localparam logic [CfgDataW-1:0] PosLimitRst = 32'd10000;
  localparam logic [CfgDataW-1:0] NegLimitRst = 32'hFFFF_D8F0;
  localparam logic [MsW-1:0]      MsRst       = 9'd4;
  localparam logic [8:0]          RndFull     = 9'd256;
  localparam logic signed [VelW-1:0] VelUp    = 6'sd25;
  localparam logic signed [VelW-1:0] VelDown  = -6'sd25;

  localparam logic [CfgIdxW-1:0] CfgPosLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNegLimit = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMsSize   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgFullStep = 2'd3;

  typedef enum logic [OpW-1:0] {
    OP_SET_TARGET = 3'd0,
    OP_SET_POS    = 3'd1,
    OP_MOVE       = 3'd2,
    OP_SW_EN      = 3'd3,
    OP_MOTOR_EN   = 3'd4,
    OP_DEFAULTS   = 3'd5,
    OP_READ       = 3'd6
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_ROUND,
    ST_WAIT,
    ST_CHECK,
    ST_MUL,
    ST_STEP,
    ST_PCLAMP,
    ST_NCLAMP,
    ST_COMMIT,
    ST_SETTLE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic latch;
    logic exec;
    logic div_start;
    logic div_step;
    logic rnd_apply;
    logic mul_start;
    logic mul_step;
    logic mv_step;
    logic mv_pclamp;
    logic mv_nclamp;
    logic mv_commit;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic full_step;
    logic go;
    logic motor;
    logic div_last;
    logic mul_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/smls_ctrl.sv -----
`default_nettype none
`include "stepper_motor_limit_switch_model_top_assert.svh"
module smls_ctrl import smls_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid_i,
  output logic     s_tready_o,
  input  logic     m_tready_i,
  output logic     m_tvalid_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat_i.op == OP_SET_TARGET && stat_i.full_step) state_d = ST_DIV;
        else if (stat_i.op == OP_MOVE) state_d = ST_WAIT;
        else state_d = ST_SETTLE;
      end
      ST_DIV: begin
        if (stat_i.div_last) state_d = ST_ROUND;
      end
      ST_ROUND:  state_d = ST_SETTLE;
      ST_WAIT:   state_d = ST_CHECK;
      ST_CHECK: begin
        state_d = stat_i.go ? ST_MUL : ST_SETTLE;
      end
      ST_MUL: begin
        if (stat_i.mul_last) state_d = ST_STEP;
      end
      ST_STEP: begin
        state_d = stat_i.motor ? ST_PCLAMP : ST_SETTLE;
      end
      ST_PCLAMP: state_d = ST_NCLAMP;
      ST_NCLAMP: state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_SETTLE;
      ST_SETTLE: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || m_tready_i) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o  = 1'b1;
        cmd_o.latch = s_tvalid_i;
      end
      ST_EXEC: begin
        cmd_o.exec      = 1'b1;
        cmd_o.div_start = (stat_i.op == OP_SET_TARGET) && stat_i.full_step;
      end
      ST_DIV:    cmd_o.div_step  = 1'b1;
      ST_ROUND:  cmd_o.rnd_apply = 1'b1;
      ST_CHECK:  cmd_o.mul_start = stat_i.go;
      ST_MUL:    cmd_o.mul_step  = 1'b1;
      ST_STEP:   cmd_o.mv_step   = 1'b1;
      ST_PCLAMP: cmd_o.mv_pclamp = 1'b1;
      ST_NCLAMP: cmd_o.mv_nclamp = 1'b1;
      ST_COMMIT: cmd_o.mv_commit = 1'b1;
      ST_DONE:   cmd_o.out_load  = !out_valid_q || m_tready_i;
      default: begin
      end
    endcase
  end

  // a new result refills the slot in the cycle the old one transfers
  always_comb begin
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (m_tready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  assign m_tvalid_o = out_valid_q;

  `SMLS_ASSERT(a_no_overwrite, clk_i, rst_ni, cmd_o.out_load |-> (!out_valid_q || m_tready_i))
  `SMLS_ASSERT_NEXT(a_accept_exec, clk_i, rst_ni, s_tvalid_i && s_tready_o, state_q == ST_EXEC)
  `SMLS_ASSERT_NEXT(a_mul_to_step, clk_i, rst_ni, state_q == ST_MUL && stat_i.mul_last, state_q == ST_STEP)

endmodule
`default_nettype wire

// ----- rtl/core/smls_dp.sv -----
`default_nettype none
module smls_dp import smls_pkg::*; #(
  parameter int unsigned POS_WIDTH  = PosWidthDef,
  parameter int unsigned PHASE_BITS = PhaseBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_addr_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  input  logic [InTdataW-1:0]  in_tdata_i,
  input  logic [OpW-1:0]       in_tuser_i,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  output logic [OutTdataW-1:0] out_tdata_o
);

  localparam int unsigned XW = (POS_WIDTH > 32) ? POS_WIDTH : 32;
  localparam int unsigned PW = POS_WIDTH + FracW;
  localparam int unsigned MW = (PHASE_BITS > MsCountW) ? PHASE_BITS : MsCountW;

  // configuration
  logic [CfgDataW-1:0] plim_cfg_q, nlim_cfg_q;
  logic [MsW-1:0]      ms_cfg_q;
  logic                fstep_q;

  // latched command
  op_e                  op_q;
  logic [POS_WIDTH-1:0] sv_q;
  logic [FracW-1:0]     frac_q;
  logic blk_in_q, force_in_q, zero_in_q, pen_in_q, nen_in_q, men_in_q;

  // model state
  logic [POS_WIDTH-1:0] abs_q, log_q, goal_q;
  logic pos_on_q, neg_on_q, motor_q, blocked_q, forced_q;

  // registered status flags
  logic up_q, pos_act_q, neg_act_q, eq_q, stepping_q;

  // rounding divider
  logic [MsW-1:0]     rem_q;
  logic [7:0]         dvd_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic               rnd_down_q;

  // fraction multiplier and move
  logic [POS_WIDTH-1:0] mag_q, absg_q;
  logic [PW-1:0]        prod_q;
  logic [MulCntW-1:0]   mul_cnt_q;
  logic                 mv_up_q;

  logic [OutTdataW-1:0] out_q;

  logic [XW-1:0]        plim_x, nlim_x, sv_x;
  logic [POS_WIDTH-1:0] plim_w, nlim_w;
  logic [MsW-1:0]       ms_eff;

  assign plim_x = XW'($signed(plim_cfg_q));
  assign nlim_x = XW'($signed(nlim_cfg_q));
  assign sv_x   = XW'($signed(in_tdata_i[31:0]));
  assign plim_w = plim_x[POS_WIDTH-1:0];
  assign nlim_w = nlim_x[POS_WIDTH-1:0];
  assign ms_eff = (ms_cfg_q == '0) ? MsW'(1) : ms_cfg_q;

  // switch reading and stepping condition
  logic pos_act_c, neg_act_c, up_c, eq_c, stepping_c;
  assign pos_act_c  = forced_q | (pos_on_q & !($signed(abs_q) < $signed(plim_w)));
  assign neg_act_c  = forced_q | (neg_on_q & !($signed(nlim_w) < $signed(abs_q)));
  assign up_c       = $signed(log_q) < $signed(goal_q);
  assign eq_c       = (log_q == goal_q);
  assign stepping_c = !eq_c && !blocked_q && (up_c ? !pos_act_c : !neg_act_c);

  // rounding phase
  logic [16:0]    rnd_prod;
  logic [7:0]     rnd_d;
  logic [9:0]     div_trial;
  logic           div_ge;
  logic [POS_WIDTH-1:0] rnd_q_ext;
  assign rnd_prod  = 17'(sv_q[7:0] * ms_eff);
  assign rnd_d     = rnd_prod[7:0];
  assign div_trial = {rem_q, dvd_q[7]};
  assign div_ge    = div_trial >= {1'b0, ms_eff};
  assign rnd_q_ext = POS_WIDTH'(dvd_q);

  // multiplier step and signed move distance
  logic [FracW-1:0]     frac_c;
  logic [POS_WIDTH:0]   mul_sum;
  logic [POS_WIDTH-1:0] step_mag, step_s;
  assign frac_c   = (frac_q > FracOne) ? FracOne : frac_q;
  assign mul_sum  = {1'b0, prod_q[PW-1:FracW]} + (prod_q[0] ? {1'b0, mag_q} : '0);
  assign step_mag = prod_q[POS_WIDTH+15:16];
  assign step_s   = mv_up_q ? step_mag : POS_WIDTH'(-step_mag);

  // result assembly
  logic [XW-1:0]           cur_x, tgt_x, dec_x;
  logic                    mv_c;
  logic signed [VelW-1:0]  vel_c;
  logic [PHASE_BITS-1:0]   ph_c;
  logic [MsCountW-1:0]     msc_c;
  logic [OutTdataW-1:0]    out_c;

  assign cur_x = XW'($signed(log_q));
  assign tgt_x = XW'($signed(goal_q));
  assign dec_x = XW'($signed(abs_q)) - XW'($signed(nlim_w));
  assign mv_c  = motor_q & stepping_q;
  assign vel_c = mv_c ? (up_q ? VelUp : VelDown) : '0;
  assign ph_c  = PHASE_BITS'(log_q[PHASE_BITS-1:0] * ms_eff) - PHASE_BITS'(1);
  assign msc_c = MsCountW'(MW'(ph_c));
  assign out_c = {3'b000, motor_q, eq_q, neg_act_q, pos_act_q, mv_c, msc_c, vel_c,
                  dec_x[31:0], tgt_x[31:0], cur_x[31:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plim_cfg_q <= PosLimitRst;
      nlim_cfg_q <= NegLimitRst;
      ms_cfg_q   <= MsRst;
      fstep_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgPosLimit: plim_cfg_q <= cfg_wdata_i;
        CfgNegLimit: nlim_cfg_q <= cfg_wdata_i;
        CfgMsSize:   ms_cfg_q   <= cfg_wdata_i[MsW-1:0];
        CfgFullStep: fstep_q    <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_q      <= '0;
      log_q      <= '0;
      goal_q     <= '0;
      pos_on_q   <= 1'b1;
      neg_on_q   <= 1'b1;
      motor_q    <= 1'b0;
      blocked_q  <= 1'b0;
      forced_q   <= 1'b0;
      up_q       <= 1'b0;
      pos_act_q  <= 1'b0;
      neg_act_q  <= 1'b0;
      eq_q       <= 1'b1;
      stepping_q <= 1'b0;
    end else begin
      up_q       <= up_c;
      pos_act_q  <= pos_act_c;
      neg_act_q  <= neg_act_c;
      eq_q       <= eq_c;
      stepping_q <= stepping_c;
      if (cmd_i.exec) begin
        unique case (op_q)
          OP_SET_TARGET: begin
            if (!fstep_q) goal_q <= sv_q;
          end
          OP_SET_POS: log_q <= sv_q;
          OP_MOVE: begin
            if (zero_in_q) begin
              abs_q    <= '0;
              log_q    <= '0;
              goal_q   <= '0;
              pos_on_q <= 1'b1;
              neg_on_q <= 1'b1;
            end
            forced_q  <= force_in_q;
            blocked_q <= blk_in_q;
          end
          OP_SW_EN: begin
            pos_on_q <= pen_in_q;
            neg_on_q <= nen_in_q;
          end
          OP_MOTOR_EN: motor_q <= men_in_q;
          OP_DEFAULTS: begin
            abs_q     <= '0;
            log_q     <= '0;
            goal_q    <= '0;
            pos_on_q  <= 1'b1;
            neg_on_q  <= 1'b1;
            forced_q  <= 1'b0;
            blocked_q <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.rnd_apply) begin
        goal_q <= rnd_down_q ? (sv_q - rnd_q_ext) : (sv_q + rnd_q_ext);
      end
      // unpowered: only the logical position moves
      if (cmd_i.mv_step && !motor_q) log_q <= log_q + step_s;
      // logical position follows the distance the absolute one really went
      if (cmd_i.mv_commit) begin
        abs_q <= absg_q;
        log_q <= log_q + absg_q - abs_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q       <= op_e'(in_tuser_i);
      sv_q       <= sv_x[POS_WIDTH-1:0];
      frac_q     <= in_tdata_i[48:32];
      blk_in_q   <= in_tdata_i[49];
      force_in_q <= in_tdata_i[50];
      zero_in_q  <= in_tdata_i[51];
      pen_in_q   <= in_tdata_i[52];
      nen_in_q   <= in_tdata_i[53];
      men_in_q   <= in_tdata_i[54];
    end
    if (cmd_i.div_start) begin
      rem_q      <= '0;
      dvd_q      <= rnd_d[7] ? 8'(RndFull - {1'b0, rnd_d}) : rnd_d;
      rnd_down_q <= !rnd_d[7];
      div_cnt_q  <= DivCntW'(DivSteps - 1);
    end else if (cmd_i.div_step) begin
      rem_q     <= div_ge ? MsW'(div_trial - {1'b0, ms_eff}) : div_trial[MsW-1:0];
      dvd_q     <= {dvd_q[6:0], div_ge};
      div_cnt_q <= div_cnt_q - 1'b1;
    end
    if (cmd_i.mul_start) begin
      mag_q     <= up_q ? (goal_q - log_q) : (log_q - goal_q);
      mv_up_q   <= up_q;
      prod_q    <= {{POS_WIDTH{1'b0}}, frac_c};
      mul_cnt_q <= MulCntW'(FracW - 1);
    end else if (cmd_i.mul_step) begin
      prod_q    <= {mul_sum, prod_q[FracW-1:1]};
      mul_cnt_q <= mul_cnt_q - 1'b1;
    end
    if (cmd_i.mv_step) begin
      absg_q <= abs_q + step_s;
    end else if (cmd_i.mv_pclamp) begin
      if (pos_on_q && ($signed(plim_w) < $signed(absg_q))) absg_q <= plim_w;
    end else if (cmd_i.mv_nclamp) begin
      if (neg_on_q && ($signed(absg_q) < $signed(nlim_w))) absg_q <= nlim_w;
    end
    if (cmd_i.out_load) out_q <= out_c;
  end

  assign out_tdata_o = out_q;

  assign stat_o.op        = op_q;
  assign stat_o.full_step = fstep_q;
  assign stat_o.go        = stepping_q && (frac_q != '0);
  assign stat_o.motor     = motor_q;
  assign stat_o.div_last  = (div_cnt_q == '0);
  assign stat_o.mul_last  = (mul_cnt_q == '0);

endmodule
`default_nettype wire

// ----- rtl/core/stepper_motor_limit_switch_model_top.sv -----
// A plain command passes through execute, settle and done before its result is valid;
// set target with full-step rounding adds a restoring divider and a rounding step,
// and a move adds wait and check states, then, if it steps, a shift-add fraction
// multiplier and a step state, then, when powered, clamp and commit. One command is in
// flight at a time and the next transfer can be taken in the cycle after the result is
// loaded; a stalled result register holds the controller until it drains. The next
// transfer is taken while the previous result still waits in the output register.
// Reset (async, active low) restores default state and config register values at once.
`default_nettype none
module stepper_motor_limit_switch_model_top import smls_pkg::*; #(
  parameter int unsigned POS_WIDTH  = PosWidthDef,
  parameter int unsigned PHASE_BITS = PhaseBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_addr_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // step_value[31:0], move_fraction[48:32], block_motor[49], force_switches[50],
  // zero_all[51], pos_switch_enable_in[52], neg_switch_enable_in[53],
  // motor_enable_in[54], zero pad[55]
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  // opcode[2:0]
  input  logic [OpW-1:0]       s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // current_position[31:0], target_position[63:32], decoder_position[95:64],
  // velocity[101:96], microstep_count[111:102], moving[112], pos_switch_active[113],
  // neg_switch_active[114], target_reached[115], motor_enabled[116], zero pad[119:117]
  output logic [OutTdataW-1:0] m_axis_tdata_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  smls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  smls_dp #(
    .POS_WIDTH  (POS_WIDTH),
    .PHASE_BITS (PHASE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_tdata_i  (s_axis_tdata_i),
    .in_tuser_i  (s_axis_tuser_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_tdata_o (m_axis_tdata_o)
  );

endmodule
`default_nettype wire
